// ===== rtl/lbs_pkg.sv =====
// Shared types and codes for the linear blend skinning block.
`default_nettype none

package lbs_pkg;

   // Item kinds carried in the request tuser field.
   localparam logic [1:0] ACT_POSE = 2'd0;
   localparam logic [1:0] ACT_BIND = 2'd1;
   localparam logic [1:0] ACT_TERM = 2'd2;

   // Which product a row operation in the datapath belongs to.
   typedef enum logic [1:0] {
      PH_BIND,
      PH_POSE,
      PH_WEIGHT
   } phase_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic      wr_pose;
      logic      wr_bind;
      logic      latch;
      logic      issue;
      phase_type phase;
      logic [1:0] row;
      logic      emit;
   } lbs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_busy;
   } lbs_stat_type;

endpackage

`default_nettype wire

// ===== rtl/lbs_mat_store.sv =====
// Matrix store for one pose set: four column banks, one row read per cycle.
`default_nettype none

module lbs_mat_store #(
   parameter int ROWS = 128,
   parameter int RA_W = 7
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [RA_W-1:0]      wr_row,
   input  wire logic [1:0]           wr_col,
   input  wire logic [31:0]          wr_data,
   input  wire logic                 rd_en,
   input  wire logic [RA_W-1:0]      rd_row,
   output logic      [3:0][31:0]     rd_data
);

   for (genvar k = 0; k < 4; k++) begin : g_bank
      logic [31:0] mem_ff [ROWS];
      logic [31:0] rd_ff;

      always_ff @(posedge clock) begin
         if (wr_en && (wr_col == 2'(k))) begin
            mem_ff[wr_row] <= wr_data;
         end
         if (rd_en) begin
            rd_ff <= mem_ff[rd_row];
         end
      end

      assign rd_data[k] = rd_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/lbs_ctrl.sv =====
// Sequencer for the skinning block: accepts words and steps the datapath.
`default_nettype none

module lbs_ctrl #(
   parameter int JOINT_COUNT = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           action,
   input  wire logic [4:0]           joint,
   input  wire logic [15:0]          weight,
   input  wire logic                 last,
   input  wire lbs_pkg::lbs_stat_type stat,
   output lbs_pkg::lbs_cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIND,
      ST_GAP1,
      ST_POSE,
      ST_GAP2,
      ST_WEIGHT,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       last_ff, last_in;
   logic       accept;
   logic       in_range;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign in_range  = ({4'b0, joint} < 9'(JOINT_COUNT));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;

      cmd         = '0;
      cmd.phase   = lbs_pkg::PH_BIND;
      cmd.row     = cnt_ff;
      cmd.wr_pose = accept && (action == lbs_pkg::ACT_POSE) && in_range;
      cmd.wr_bind = accept && (action == lbs_pkg::ACT_BIND) && in_range;
      cmd.latch   = accept && (action == lbs_pkg::ACT_TERM);

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.latch) begin
               last_in = last;
               cnt_in  = '0;
               // A term that contributes nothing still closes the vertex.
               if (in_range && (weight != '0)) begin
                  state_in = ST_BIND;
               end else if (last) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_BIND: begin
            cmd.issue = 1'b1;
            cmd.phase = lbs_pkg::PH_BIND;
            cnt_in    = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_GAP1;
               cnt_in   = '0;
            end
         end
         ST_GAP1: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd1) begin
               state_in = ST_POSE;
               cnt_in   = '0;
            end
         end
         ST_POSE: begin
            cmd.issue = 1'b1;
            cmd.phase = lbs_pkg::PH_POSE;
            cnt_in    = cnt_ff + 2'd1;
            if (cnt_ff == 2'd2) begin
               state_in = ST_GAP2;
               cnt_in   = '0;
            end
         end
         ST_GAP2: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd1) begin
               state_in = ST_WEIGHT;
               cnt_in   = '0;
            end
         end
         ST_WEIGHT: begin
            cmd.issue = 1'b1;
            cmd.phase = lbs_pkg::PH_WEIGHT;
            state_in  = ST_DRAIN;
            cnt_in    = '0;
         end
         ST_DRAIN: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd2) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
               cnt_in   = '0;
            end
         end
         ST_EMIT: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lbs_datapath.sv =====
// Skinning datapath: matrix stores, four multiplier lanes, row sums and accumulators.
`default_nettype none

module lbs_datapath #(
   parameter int JOINT_COUNT = 32,
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lbs_pkg::lbs_cmd_type  cmd,
   output lbs_pkg::lbs_stat_type      stat,
   input  wire logic [4:0]            joint,
   input  wire logic [3:0]            entry,
   input  wire logic [31:0]           entry_value,
   input  wire logic [15:0]           weight,
   input  wire logic [31:0]           vertex_x,
   input  wire logic [31:0]           vertex_y,
   input  wire logic [31:0]           vertex_z,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic [31:0]                out_x,
   output logic [31:0]                out_y,
   output logic [31:0]                out_z,
   output logic                       clipped
);

   localparam int ROWS   = JOINT_COUNT * 4;
   localparam int RA_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int AF_W   = (RA_W > 7) ? RA_W : 7;
   localparam int MUL_CW = 48;
   localparam int ACC_W  = 48;

   localparam logic signed [63:0] TERM_MAX = 64'sd1 <<< 60;
   localparam logic signed [63:0] TERM_MIN = -(64'sd1 <<< 60);
   localparam logic signed [63:0] CW_MAX   = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] CW_MIN   = -(64'sd1 <<< (COORD_WIDTH - 1));
   localparam logic signed [63:0] ACC_MAX  = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
   localparam logic signed [63:0] ACC_MIN  = -(64'sd1 <<< (ACC_W - 1));
   localparam logic signed [ACC_W-1:0] O_MAX = 48'sd2147483647;
   localparam logic signed [ACC_W-1:0] O_MIN = -48'sd2147483648;
   localparam logic signed [MUL_CW-1:0] ONE_Q16 = 48'sd65536;

   // Latched weight-term item.
   logic [4:0]         joint_ff;
   logic [15:0]        weight_ff;
   logic signed [31:0] vx_ff, vy_ff, vz_ff;

   // Matrix store addressing.
   logic [AF_W-1:0]    wr_wide, rd_wide;
   logic [RA_W-1:0]    wr_row, rd_row;
   logic [3:0][31:0]   pose_rd, bind_rd;

   // Pipeline tags: multiply, term and sum stages.
   logic                  s1_valid_ff, s2_valid_ff, s3_valid_ff;
   lbs_pkg::phase_type    s1_phase_ff, s2_phase_ff, s3_phase_ff;
   logic [1:0]            s1_row_ff, s2_row_ff, s3_row_ff;

   // Lane operands and products.
   logic signed [31:0]        m_v [4];
   logic signed [MUL_CW-1:0]  c_v [4];
   logic signed [MUL_CW-1:0]  u_ext [4];
   logic signed [MUL_CW-1:0]  vec_b [4];
   logic signed [63:0]        p_hi_in [4];
   logic signed [48:0]        p_lo_in [4];
   logic signed [63:0]        p_hi_ff [4];
   logic signed [48:0]        p_lo_ff [4];
   logic signed [63:0]        term_in [4];
   logic signed [63:0]        term_ff [4];

   // Row results and accumulators.
   logic signed [COORD_WIDTH-1:0] t_ff [4];
   logic signed [COORD_WIDTH-1:0] u_ff [3];
   logic signed [63:0]            row_sum;
   logic signed [63:0]            row_sat;
   logic signed [ACC_W-1:0]       acc_ff [3];
   logic signed [ACC_W-1:0]       acc_in [3];
   logic signed [63:0]            acc_sum [3];

   // Output word.
   logic        rsp_valid_ff;
   logic [31:0] out_ff [3];
   logic [31:0] out_in [3];
   logic        clipped_ff;
   logic        clipped_in;

   assign wr_wide = AF_W'({joint, entry[3:2]});
   assign wr_row  = wr_wide[RA_W-1:0];
   assign rd_wide = AF_W'({joint_ff, cmd.row});
   assign rd_row  = rd_wide[RA_W-1:0];

   lbs_mat_store #(
      .ROWS (ROWS),
      .RA_W (RA_W)
   ) u_pose (
      .clock   (clock),
      .wr_en   (cmd.wr_pose),
      .wr_row  (wr_row),
      .wr_col  (entry[1:0]),
      .wr_data (entry_value),
      .rd_en   (cmd.issue),
      .rd_row  (rd_row),
      .rd_data (pose_rd)
   );

   lbs_mat_store #(
      .ROWS (ROWS),
      .RA_W (RA_W)
   ) u_bind (
      .clock   (clock),
      .wr_en   (cmd.wr_bind),
      .wr_row  (wr_row),
      .wr_col  (entry[1:0]),
      .wr_data (entry_value),
      .rd_en   (cmd.issue),
      .rd_row  (rd_row),
      .rd_data (bind_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         joint_ff  <= joint;
         weight_ff <= weight;
         vx_ff     <= vertex_x;
         vy_ff     <= vertex_y;
         vz_ff     <= vertex_z;
      end
   end

   assign vec_b[0] = MUL_CW'(vx_ff);
   assign vec_b[1] = MUL_CW'(vy_ff);
   assign vec_b[2] = MUL_CW'(vz_ff);
   assign vec_b[3] = ONE_Q16;
   assign u_ext[0] = MUL_CW'(u_ff[0]);
   assign u_ext[1] = MUL_CW'(u_ff[1]);
   assign u_ext[2] = MUL_CW'(u_ff[2]);
   assign u_ext[3] = '0;

   // Multiply stage. The coordinate splits into a signed high part and an
   // unsigned low 16 bits so each lane needs only a 32 by 32 product.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         unique case (s1_phase_ff)
            lbs_pkg::PH_BIND: begin
               m_v[k] = $signed(bind_rd[k]);
               c_v[k] = vec_b[k];
            end
            lbs_pkg::PH_POSE: begin
               m_v[k] = $signed(pose_rd[k]);
               c_v[k] = MUL_CW'(t_ff[k]);
            end
            lbs_pkg::PH_WEIGHT: begin
               m_v[k] = $signed({16'b0, weight_ff});
               c_v[k] = u_ext[k];
            end
            default: begin
               m_v[k] = '0;
               c_v[k] = '0;
            end
         endcase
         p_hi_in[k] = m_v[k] * $signed(c_v[k][MUL_CW-1:16]);
         p_lo_in[k] = m_v[k] * $signed({1'b0, c_v[k][15:0]});
      end
   end

   // Term stage: a matrix term is floor(m*c/2^16) clamped; a weighted term is
   // floor(w*u/2^15), rebuilt from the same split products.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (s2_phase_ff == lbs_pkg::PH_WEIGHT) begin
            term_in[k] = (p_hi_ff[k] <<< 1) + (p_lo_ff[k] >>> 15);
         end else begin
            term_in[k] = p_hi_ff[k] + (p_lo_ff[k] >>> 16);
            if (term_in[k] > TERM_MAX) begin
               term_in[k] = TERM_MAX;
            end else if (term_in[k] < TERM_MIN) begin
               term_in[k] = TERM_MIN;
            end
         end
      end
   end

   // Sum stage.
   always_comb begin
      row_sum = term_ff[0] + term_ff[1] + term_ff[2] + term_ff[3];
      if (row_sum > CW_MAX) begin
         row_sat = CW_MAX;
      end else if (row_sum < CW_MIN) begin
         row_sat = CW_MIN;
      end else begin
         row_sat = row_sum;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         acc_sum[k] = 64'(acc_ff[k]) + term_ff[k];
         acc_in[k]  = acc_ff[k];
         if (cmd.emit) begin
            acc_in[k] = '0;
         end else if (s3_valid_ff && (s3_phase_ff == lbs_pkg::PH_WEIGHT)) begin
            if (acc_sum[k] > ACC_MAX) begin
               acc_in[k] = ACC_MAX[ACC_W-1:0];
            end else if (acc_sum[k] < ACC_MIN) begin
               acc_in[k] = ACC_MIN[ACC_W-1:0];
            end else begin
               acc_in[k] = acc_sum[k][ACC_W-1:0];
            end
         end
      end
   end

   always_comb begin
      clipped_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (acc_ff[k] > O_MAX) begin
            out_in[k]  = 32'h7FFF_FFFF;
            clipped_in = 1'b1;
         end else if (acc_ff[k] < O_MIN) begin
            out_in[k]  = 32'h8000_0000;
            clipped_in = 1'b1;
         end else begin
            out_in[k] = acc_ff[k][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            acc_ff[k] <= '0;
         end
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         for (int k = 0; k < 3; k++) begin
            acc_ff[k] <= acc_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_phase_ff <= cmd.phase;
      s1_row_ff   <= cmd.row;
      s2_phase_ff <= s1_phase_ff;
      s2_row_ff   <= s1_row_ff;
      s3_phase_ff <= s2_phase_ff;
      s3_row_ff   <= s2_row_ff;
      for (int k = 0; k < 4; k++) begin
         p_hi_ff[k] <= p_hi_in[k];
         p_lo_ff[k] <= p_lo_in[k];
         term_ff[k] <= term_in[k];
      end
      if (s3_valid_ff) begin
         if (s3_phase_ff == lbs_pkg::PH_BIND) begin
            t_ff[s3_row_ff] <= row_sat[COORD_WIDTH-1:0];
         end else if ((s3_phase_ff == lbs_pkg::PH_POSE) && (s3_row_ff != 2'd3)) begin
            u_ff[s3_row_ff] <= row_sat[COORD_WIDTH-1:0];
         end
      end
      if (cmd.emit) begin
         for (int k = 0; k < 3; k++) begin
            out_ff[k] <= out_in[k];
         end
         clipped_ff <= clipped_in;
      end
   end

   assign stat.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign out_x         = out_ff[0];
   assign out_y         = out_ff[1];
   assign out_z         = out_ff[2];
   assign clipped       = clipped_ff;

endmodule

`default_nettype wire

// ===== rtl/linear_blend_skinning.sv =====
// Top level of the linear blend skinning block.
//
//   channel   direction   word contents
//   req_*     in          matrix entry load or weight term of a vertex
//   rsp_*     out         skinned vertex x, y, z and clip flag
//
// A weight term with an in-range joint and a nonzero weight issues the bind
// rows, the pose rows and the weight step on the four multiplier lanes, one
// matrix row per cycle, waiting on the row-to-row dependency between phases;
// no new word is taken meanwhile. A term that adds nothing but closes the
// vertex goes straight to emitting its result. Reset is synchronous and
// clears the sequencer, pipeline and accumulators; the matrix stores hold
// nothing until written. A result word waits in its register while the next
// words are taken; only a second result stalls until the first is gone.
`default_nettype none

module linear_blend_skinning #(
   parameter int JOINT_COUNT = 32,
   parameter int COORD_WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // joint_index, entry_index, entry_value, weight, vertex_x, vertex_y, vertex_z
   input  wire logic [159:0] req_tdata,
   // action
   input  wire logic [1:0]   req_tuser,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_x, out_y, out_z
   output logic [95:0]       rsp_tdata,
   // clipped
   output logic [0:0]        rsp_tuser
);

   lbs_pkg::lbs_cmd_type  cmd;
   lbs_pkg::lbs_stat_type stat;

   logic [4:0]  joint;
   logic [3:0]  entry;
   logic [31:0] entry_value;
   logic [15:0] weight;
   logic [31:0] vertex_x, vertex_y, vertex_z;
   logic [31:0] out_x, out_y, out_z;
   logic        clipped;

   assign joint       = req_tdata[4:0];
   assign entry       = req_tdata[8:5];
   assign entry_value = req_tdata[40:9];
   assign weight      = req_tdata[56:41];
   assign vertex_x    = req_tdata[88:57];
   assign vertex_y    = req_tdata[120:89];
   assign vertex_z    = req_tdata[152:121];

   lbs_ctrl #(
      .JOINT_COUNT (JOINT_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .action    (req_tuser),
      .joint     (joint),
      .weight    (weight),
      .last      (req_tlast),
      .stat      (stat),
      .cmd       (cmd)
   );

   lbs_datapath #(
      .JOINT_COUNT (JOINT_COUNT),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .joint       (joint),
      .entry       (entry),
      .entry_value (entry_value),
      .weight      (weight),
      .vertex_x    (vertex_x),
      .vertex_y    (vertex_y),
      .vertex_z    (vertex_z),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .out_x       (out_x),
      .out_y       (out_y),
      .out_z       (out_z),
      .clipped     (clipped)
   );

   assign rsp_tdata = {out_z, out_y, out_x};
   assign rsp_tuser = clipped;

   // A new result never overwrites one that is still waiting.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_tvalid && !rsp_tready))
      else $error("result register overwritten while occupied");

   // Matrix writes and row reads never share a cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !(cmd.wr_pose || cmd.wr_bind))
      else $error("matrix write during a row read");

   // An emitted result is presented in the following cycle.
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("emitted result not presented");

   // Rows are issued only while no word is being taken.
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !req_tready)
      else $error("word accepted during a row sequence");

endmodule

`default_nettype wire

// ===== dv/lbs_checker.sv =====
// Checker for the skinning block: tracks its matrices and sums and checks every result word.
module lbs_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   // joint_index, entry_index, entry_value, weight, vertex_x, vertex_y, vertex_z
   input  wire logic [159:0] req_tdata,
   // action
   input  wire logic [1:0]   req_tuser,
   input  wire logic         req_tlast,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_x, out_y, out_z
   input  wire logic [95:0]  rsp_tdata,
   // clipped
   input  wire logic [0:0]   rsp_tuser,
   output int                errors,
   output int                pending,
   output int                vertices,
   output int                clipped_count
);

   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   typedef struct packed {
      logic [2:0][31:0] xyz;
      logic             clip;
   } skinned_vertex_type;

   logic signed [31:0] pose_mem [0:511];
   logic signed [31:0] bind_mem [0:511];
   logic signed [63:0] sums [0:2];
   skinned_vertex_type vertex_q [$];

   function automatic logic signed [63:0] saturate(input logic signed [63:0] v, input int bits);
      logic signed [63:0] hi_lim;
      hi_lim = (64'sd1 <<< (bits - 1)) - 64'sd1;
      if (v > hi_lim) return hi_lim;
      if (v < -hi_lim - 64'sd1) return -hi_lim - 64'sd1;
      return v;
   endfunction

   // One matrix row times a Q16.16 vector, each product floored after the shift.
   function automatic logic signed [63:0] row_dot(input logic use_pose, input int base,
                                                 input logic [3:0][31:0] vec);
      logic signed [63:0] mval;
      logic signed [63:0] cval;
      logic signed [63:0] acc;
      acc = '0;
      for (int k = 0; k < 4; k++) begin
         mval = use_pose ? pose_mem[base + k] : bind_mem[base + k];
         cval = $signed(vec[k]);
         // Products are at most 2^62 in size, so after the shift the per-term limit of 2^60 never applies here.
         acc = acc + ((mval * cval) >>> 16);
      end
      return saturate(acc, 32);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                  input logic [31:0] want_v);
      $display("ERROR: %s is %h, expected %h", what, got_v, want_v);
      errors++;
   endtask

   always @(posedge clock) begin : monitor
      logic [4:0]         joint;
      logic [3:0]         entry;
      logic [15:0]        weight;
      logic [3:0][31:0]   vert;
      logic [3:0][31:0]   mid;
      logic signed [63:0] u;
      logic signed [63:0] wterm;
      logic signed [63:0] sat;
      skinned_vertex_type want;
      skinned_vertex_type got;
      int                 base;
      if (reset) begin
         for (int r = 0; r < 3; r++) sums[r] = '0;
         vertex_q.delete();
         errors = 0;
         pending = 0;
         vertices = 0;
         clipped_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.xyz = rsp_tdata;
            got.clip = rsp_tuser[0];
            if (vertex_q.size() == 0) begin
               report_mismatch("result word with nothing expected, out_x", got.xyz[0], '0);
            end else begin
               want = vertex_q.pop_front();
               for (int r = 0; r < 3; r++)
                  if (got.xyz[r] !== want.xyz[r])
                     report_mismatch($sformatf("coordinate %0d of vertex %0d", r, vertices),
                                     got.xyz[r], want.xyz[r]);
               if (got.clip !== want.clip)
                  report_mismatch($sformatf("clip flag of vertex %0d", vertices),
                                  32'(got.clip), 32'(want.clip));
               vertices++;
               if (got.clip) clipped_count++;
            end
         end
         if (req_tvalid && req_tready) begin
            joint = req_tdata[4:0];
            entry = req_tdata[8:5];
            weight = req_tdata[56:41];
            base = int'(joint) * 16;
            case (req_tuser)
               lbs_pkg::ACT_POSE: pose_mem[base + entry] = req_tdata[40:9];
               lbs_pkg::ACT_BIND: bind_mem[base + entry] = req_tdata[40:9];
               lbs_pkg::ACT_TERM: begin
                  // A zero weight reads no matrix and leaves the sums alone.
                  if (weight != 16'd0) begin
                     vert[0] = req_tdata[88:57];
                     vert[1] = req_tdata[120:89];
                     vert[2] = req_tdata[152:121];
                     vert[3] = ONE_Q16;
                     for (int r = 0; r < 4; r++) begin
                        u = row_dot(1'b0, base + 4 * r, vert);
                        mid[r] = u[31:0];
                     end
                     for (int r = 0; r < 3; r++) begin
                        u = row_dot(1'b1, base + 4 * r, mid);
                        wterm = ($signed({48'd0, weight}) * u) >>> 15;
                        sums[r] = saturate(sums[r] + wterm, 48);
                     end
                  end
                  if (req_tlast) begin
                     want.clip = 1'b0;
                     for (int r = 0; r < 3; r++) begin
                        sat = saturate(sums[r], 32);
                        if (sat != sums[r]) want.clip = 1'b1;
                        want.xyz[r] = sat[31:0];
                        sums[r] = '0;
                     end
                     vertex_q = {vertex_q, want};
                  end
               end
               default: ;
            endcase
         end
         pending = vertex_q.size();
      end
   end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the skinning block: clock, reset, stimulus, flow control and verdict.
module tb_top;

   localparam logic [1:0]  ACT_NONE = 2'd3;
   localparam int          ITEM_TARGET = 1150;
   localparam int          HOLD_CYCLES = 400;
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
   localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] COORD_MIN = 32'h8000_0000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   int errors;
   int pending;
   int vertices;
   int clipped_count;

   int         item_count = 0;
   int         send_idle_pct = 35;
   int         recv_idle_pct = 75;
   bit         hold_request = 1'b0;
   bit [15:0]  pose_seen [0:31];
   bit [15:0]  bind_seen [0:31];
   bit [31:0]  ready_mask = '0;

   linear_blend_skinning u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lbs_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .errors        (errors),
      .pending       (pending),
      .vertices      (vertices),
      .clipped_count (clipped_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   // Offers one word, after a random gap, and returns at the edge that takes it.
   task automatic send_word(input logic [1:0] act, input logic [4:0] joint,
                            input logic [3:0] entry, input logic [31:0] value,
                            input logic [15:0] weight, input logic [31:0] vx,
                            input logic [31:0] vy, input logic [31:0] vz, input logic mark);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tlast <= mark;
      req_tdata <= {7'd0, vz, vy, vx, weight, value, entry, joint};
      do @(posedge clock); while (!req_tready);
      if (act != ACT_NONE) item_count++;
      if (act == lbs_pkg::ACT_POSE) pose_seen[joint][entry] = 1'b1;
      if (act == lbs_pkg::ACT_BIND) bind_seen[joint][entry] = 1'b1;
      if (&pose_seen[joint] && &bind_seen[joint]) ready_mask[joint] = 1'b1;
   endtask

   task automatic send_load(input logic [1:0] act, input logic [4:0] joint,
                            input logic [3:0] entry, input logic [31:0] value,
                            input logic mark);
      send_word(act, joint, entry, value, 16'($urandom), $urandom, $urandom, $urandom, mark);
   endtask

   task automatic send_term(input logic [4:0] joint, input logic [15:0] weight,
                            input logic [31:0] vx, input logic [31:0] vy,
                            input logic [31:0] vz, input logic mark);
      send_word(lbs_pkg::ACT_TERM, joint, 4'($urandom), $urandom, weight, vx, vy, vz, mark);
   endtask

   // Mostly near-rigid matrices so that results stay in range, with some wild entries.
   function automatic logic [31:0] entry_pick(input int e);
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return $urandom;
      if (r < 9) return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      if (e >= 12) return (e == 15) ? ONE_Q16 : 32'(int'($urandom_range(0, 8192)) - 4096);
      if (e % 4 == 3) return 32'(int'($urandom_range(0, 2097152)) - 1048576);
      if (e % 5 == 0) return 32'(65536 + int'($urandom_range(0, 32768)) - 16384);
      return 32'(int'($urandom_range(0, 65536)) - 32768);
   endfunction

   function automatic logic [31:0] coord_pick();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom;
      if (r < 14) return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      return 32'(int'($urandom_range(0, 8388608)) - 4194304);
   endfunction

   function automatic logic [15:0] weight_pick();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'd0;
      if (r < 20) return 16'd32768;
      if (r < 25) return 16'hFFFF;
      return 16'($urandom_range(1, 32768));
   endfunction

   function automatic logic [4:0] ready_joint_pick();
      logic [4:0] j;
      do j = 5'($urandom_range(0, 31)); while (!ready_mask[j]);
      return j;
   endfunction

   task automatic fill_joint(input logic [4:0] joint, input logic identity);
      for (int e = 0; e < 16; e++) begin
         send_load(lbs_pkg::ACT_POSE, joint, 4'(e),
                   identity ? ((e % 5 == 0) ? ONE_Q16 : 32'd0) : entry_pick(e), 1'b0);
         send_load(lbs_pkg::ACT_BIND, joint, 4'(e),
                   identity ? ((e % 5 == 0) ? ONE_Q16 : 32'd0) : entry_pick(e), 1'b0);
      end
   endtask

   // Result side: random back-pressure, plus one long stall once the sender runs flat out.
   initial begin : result_sink
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin : stimulus
      int         pick;
      int         nterms;
      logic [3:0] entry;
      logic [15:0] w;
      logic       mark;
      for (int j = 0; j < 32; j++) begin
         pose_seen[j] = '0;
         bind_seen[j] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Identity joint first: a term must give back the bind vertex.
      fill_joint(5'd31, 1'b1);
      send_term(5'd31, 16'd32768, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 1'b1);
      // Zero weight with extreme coordinates still closes an all-zero vertex.
      send_term(5'd31, 16'd0, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
      // Two heavy terms push the sums past 32 bits, so the output clips.
      send_term(5'd31, 16'hFFFF, COORD_MAX, COORD_MIN, 32'h0000_8000, 1'b0);
      send_term(5'd31, 16'd32768, COORD_MAX, COORD_MIN, 32'd0, 1'b1);
      send_word(ACT_NONE, 5'd31, 4'd0, COORD_MAX, 16'hFFFF, COORD_MAX, COORD_MAX,
                COORD_MAX, 1'b1);
      // Load words carrying the last mark must not emit.
      send_load(lbs_pkg::ACT_POSE, 5'd31, 4'd0, COORD_MAX, 1'b1);
      send_term(5'd31, 16'd32768, COORD_MAX, ONE_Q16, COORD_MIN, 1'b1);
      send_load(lbs_pkg::ACT_BIND, 5'd31, 4'd3, COORD_MIN, 1'b1);
      send_term(5'd31, 16'd1, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
      send_term(5'd31, 16'd32768, 32'd0, 32'd0, 32'd0, 1'b1);
      send_load(lbs_pkg::ACT_POSE, 5'd31, 4'd0, ONE_Q16, 1'b0);
      send_load(lbs_pkg::ACT_BIND, 5'd31, 4'd3, 32'd0, 1'b0);

      while (item_count < ITEM_TARGET) begin
         if (item_count >= 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_request = 1'b1;
         end else if (item_count >= ITEM_TARGET / 3) begin
            send_idle_pct = 75;
            recv_idle_pct = 35;
         end
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            send_word(ACT_NONE, 5'($urandom), 4'($urandom), $urandom, 16'($urandom),
                      $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
         end else if (pick < 20) begin
            entry = 4'($urandom_range(0, 15));
            send_load($urandom_range(0, 1) ? lbs_pkg::ACT_BIND : lbs_pkg::ACT_POSE,
                      5'($urandom), entry, entry_pick(int'(entry)),
                      1'($urandom_range(0, 1)));
         end else if (pick < 24 && $countones(ready_mask) < 8) begin
            fill_joint(5'($urandom_range(0, 31)), 1'b0);
         end else begin
            // One vertex; now and then the closing mark moves or goes missing.
            nterms = $urandom_range(1, 4);
            for (int t = 0; t < nterms; t++) begin
               w = weight_pick();
               if (t == nterms - 1) mark = ($urandom_range(0, 9) != 0);
               else mark = ($urandom_range(0, 19) == 0);
               send_term((w == 16'd0) ? 5'($urandom) : ready_joint_pick(), w, coord_pick(),
                         coord_pick(), coord_pick(), mark);
            end
         end
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Sent %0d request words; %0d skinned vertices checked, %0d of them clipped.",
               item_count, vertices, clipped_count);
      $display("Flow control went sender-heavy, receiver-heavy, then free, with one long stall.");
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
